FILE: design/blps_pkg.sv
// ----------------------------------------------------------------------------
// blps_pkg
// Shared widths, codes and types for the bump-light pixel shader.
// ----------------------------------------------------------------------------
package blps_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int COORD_W  = $clog2(MAX_DIM);
  localparam int DIFF_W   = COORD_W + 1;      // signed pixel-to-light distance
  localparam int SLOPE_W  = COORD_W + 2;      // height diff minus distance
  localparam int CH_W     = 8;
  localparam int RGB_W    = 3 * CH_W;
  localparam int TERM_W   = 7;                // 1..127
  localparam int TT_W     = 2 * TERM_W;       // term product
  localparam int DEPTH_W  = 7;
  localparam int SCALE_W  = 9;                // depth * 256 / 100, up to 325
  localparam int AMT_W    = 9;                // added amount, up to 319
  localparam int SHIFT_AMT = 8 + 6;

  localparam logic [TERM_W-1:0] TERM_MAX = 7'd127;
  localparam logic [CH_W-1:0]   CH_CAP   = 8'd254;
  localparam logic [RGB_W-1:0]  WHITE    = 24'hFFFFFF;

  // depth * 256 / 100 == depth * 64 / 25, as a multiply by ceil(2^20 / 25)
  localparam int RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_25 = 16'd41944;
  localparam int RECIP_SHIFT = 20 - 6;

  // blend modes
  localparam logic [1:0] BLEND_REPLACE = 2'd0;
  localparam logic [1:0] BLEND_ADD     = 2'd1;
  localparam logic [1:0] BLEND_MEAN    = 2'd2;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_FLAT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_LIGHT = 3'd6;
  localparam int CFG_DATA_W = COORD_W;

  // per-pixel control carried down the pipe
  typedef struct packed {
    logic wr;     // pixel gets a shaded value
    logic mark;   // light marker applies if not written
  } ctl_t;

endpackage

FILE: design/bump_light_pixel_shader.sv
// ----------------------------------------------------------------------------
// bump_light_pixel_shader
// Point-light bump shader: one pixel beat in, one shaded pixel beat out.
// ----------------------------------------------------------------------------
//
//  channel | direction | beat content
//  --------+-----------+------------------------------------------------------
//  in_     | slave     | position, border flag, color, four depth neighbors
//  out_    | master    | shaded color
//  cfg_    | write     | light position, depth, invert, blend, skip, marker
//
//  Five register stages: heights/distances, slope terms, term product,
//  scaled amount, lift/blend/output. Throughput is one beat per clock while
//  out_tready is high; a low out_tready holds the stages.
//  Each stage loads when it is empty or the stage after it moves, so bubbles
//  close up and a stalled out_ side holds everything without loss.
//  rst_n (sync, low) clears the stage valid bits and loads register resets.
//
module bump_light_pixel_shader (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, from bit 0: pixel_x[11:0], pixel_y[23:12], pixel_color[47:24],
  // height_left[71:48], height_right[95:72], height_up[119:96],
  // height_down[143:120]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [143:0]                     in_tdata,
  input  logic                             in_tuser,   // on_border
  // out_tdata, from bit 0: shaded_color[23:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [blps_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [blps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import blps_pkg::*;

  localparam int NSTG = 5;

  // ---- configuration registers -------------------------------------------
  logic [COORD_W-1:0]  light_x_r, light_y_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic                invert_r, skip_flat_r, show_light_r;
  logic [1:0]          blend_r;
  logic [SCALE_W-1:0]  scaled_r;
  logic [DEPTH_W+RECIP_W-1:0] scale_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r    <= '0;
      light_y_r    <= '0;
      depth_r      <= DEPTH_W'(30);
      invert_r     <= 1'b0;
      blend_r      <= BLEND_REPLACE;
      skip_flat_r  <= 1'b1;
      show_light_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LIGHT_X:    light_x_r    <= cfg_wdata[COORD_W-1:0];
        REG_LIGHT_Y:    light_y_r    <= cfg_wdata[COORD_W-1:0];
        REG_DEPTH:      depth_r      <= cfg_wdata[DEPTH_W-1:0];
        REG_INVERT:     invert_r     <= cfg_wdata[0];
        REG_BLEND:      blend_r      <= cfg_wdata[1:0];
        REG_SKIP_FLAT:  skip_flat_r  <= cfg_wdata[0];
        REG_SHOW_LIGHT: show_light_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // depth * 256 / 100 by reciprocal; exact for every 7-bit depth.
  // Registered into scaled_r, one register behind depth_r.
  assign scale_prod = (DEPTH_W+RECIP_W)'(depth_r) * (DEPTH_W+RECIP_W)'(RECIP_25);

  always_ff @(posedge clk) begin
    scaled_r <= SCALE_W'(scale_prod >> RECIP_SHIFT);
  end

  // ---- stage valid bits and load enables ----------------------------------
  logic [NSTG-1:0] valid_r, valid_nxt;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !valid_r[NSTG-1] || out_tready;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt = valid_r;
    if (en[0]) valid_nxt[0] = in_tvalid;
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) valid_nxt[k] = valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else        valid_r <= valid_nxt;
  end

  assign in_tready  = en[0];
  assign out_tvalid = valid_r[NSTG-1];

  // ---- datapath -----------------------------------------------------------
  logic [TERM_W-1:0] term_h, term_v;
  logic              term_pos;
  logic [RGB_W-1:0]  src2, src4;
  ctl_t              ctl2, ctl4;
  logic [AMT_W-1:0]  amount;

  blps_slope u_slope (
    .clk           (clk),
    .en1           (en[0]),
    .en2           (en[1]),
    .invert_height (invert_r),
    .skip_flat     (skip_flat_r),
    .show_light    (show_light_r),
    .light_x       (light_x_r),
    .light_y       (light_y_r),
    .pixel_x       (in_tdata[11:0]),
    .pixel_y       (in_tdata[23:12]),
    .on_border     (in_tuser),
    .pixel_color   (in_tdata[47:24]),
    .height_left   (in_tdata[71:48]),
    .height_right  (in_tdata[95:72]),
    .height_up     (in_tdata[119:96]),
    .height_down   (in_tdata[143:120]),
    .term_h        (term_h),
    .term_v        (term_v),
    .term_pos      (term_pos),
    .src           (src2),
    .ctl           (ctl2)
  );

  blps_gain u_gain (
    .clk          (clk),
    .en3          (en[2]),
    .en4          (en[3]),
    .scaled_depth (scaled_r),
    .term_h       (term_h),
    .term_v       (term_v),
    .term_pos     (term_pos),
    .src_in       (src2),
    .ctl_in       (ctl2),
    .amount       (amount),
    .src_out      (src4),
    .ctl_out      (ctl4)
  );

  blps_blend u_blend (
    .clk        (clk),
    .en5        (en[4]),
    .blend_mode (blend_r),
    .amount     (amount),
    .src        (src4),
    .ctl        (ctl4),
    .color      (out_tdata)
  );

endmodule

FILE: design/blps_slope.sv
// ----------------------------------------------------------------------------
// blps_slope
// Stages 1-2: neighbour heights, light distance, slope terms.
// ----------------------------------------------------------------------------
module blps_slope (
  input  logic                          clk,
  input  logic                          en1,
  input  logic                          en2,
  input  logic                          invert_height,
  input  logic                          skip_flat,
  input  logic                          show_light,
  input  logic [blps_pkg::COORD_W-1:0]  light_x,
  input  logic [blps_pkg::COORD_W-1:0]  light_y,
  input  logic [blps_pkg::COORD_W-1:0]  pixel_x,
  input  logic [blps_pkg::COORD_W-1:0]  pixel_y,
  input  logic                          on_border,
  input  logic [blps_pkg::RGB_W-1:0]    pixel_color,
  input  logic [blps_pkg::RGB_W-1:0]    height_left,
  input  logic [blps_pkg::RGB_W-1:0]    height_right,
  input  logic [blps_pkg::RGB_W-1:0]    height_up,
  input  logic [blps_pkg::RGB_W-1:0]    height_down,
  output logic [blps_pkg::TERM_W-1:0]   term_h,
  output logic [blps_pkg::TERM_W-1:0]   term_v,
  output logic                          term_pos,
  output logic [blps_pkg::RGB_W-1:0]    src,
  output blps_pkg::ctl_t                ctl
);
  import blps_pkg::*;

  function automatic logic [CH_W-1:0] height_of(input logic [RGB_W-1:0] c,
                                               input logic inv);
    logic [CH_W-1:0] m;
    m = c[7:0];
    if (c[15:8] > m) m = c[15:8];
    if (c[23:16] > m) m = c[23:16];
    return inv ? ~m : m;
  endfunction

  // stage 1
  logic [CH_W-1:0]          hl_r, hr_r, hu_r, hd_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [RGB_W-1:0]         src1_r;
  ctl_t                     ctl1_r;
  logic                     flat;

  assign flat = skip_flat && (height_left == '0) && (height_right == '0) &&
                (height_up == '0) && (height_down == '0);

  always_ff @(posedge clk) begin
    if (en1) begin
      hl_r        <= height_of(height_left, invert_height);
      hr_r        <= height_of(height_right, invert_height);
      hu_r        <= height_of(height_up, invert_height);
      hd_r        <= height_of(height_down, invert_height);
      dx_r        <= $signed({1'b0, pixel_x}) - $signed({1'b0, light_x});
      dy_r        <= $signed({1'b0, pixel_y}) - $signed({1'b0, light_y});
      src1_r      <= pixel_color;
      ctl1_r.wr   <= !on_border && !flat;
      ctl1_r.mark <= show_light && (pixel_x == light_x) && (pixel_y == light_y);
    end
  end

  // stage 2
  logic signed [SLOPE_W-1:0] slope_h, slope_v;
  logic [SLOPE_W-1:0]        abs_h, abs_v;
  logic [TERM_W-1:0]         th_r, tv_r;
  logic                      pos_r;
  logic [RGB_W-1:0]          src2_r;
  ctl_t                      ctl2_r;

  assign slope_h = $signed({{(SLOPE_W-CH_W){1'b0}}, hr_r})
                 - $signed({{(SLOPE_W-CH_W){1'b0}}, hl_r})
                 - SLOPE_W'(dx_r);
  assign slope_v = $signed({{(SLOPE_W-CH_W){1'b0}}, hd_r})
                 - $signed({{(SLOPE_W-CH_W){1'b0}}, hu_r})
                 - SLOPE_W'(dy_r);
  assign abs_h = slope_h[SLOPE_W-1] ? SLOPE_W'(-slope_h) : SLOPE_W'(slope_h);
  assign abs_v = slope_v[SLOPE_W-1] ? SLOPE_W'(-slope_v) : SLOPE_W'(slope_v);

  always_ff @(posedge clk) begin
    if (en2) begin
      th_r   <= TERM_MAX - abs_h[TERM_W-1:0];
      tv_r   <= TERM_MAX - abs_v[TERM_W-1:0];
      pos_r  <= (abs_h < SLOPE_W'(TERM_MAX)) && (abs_v < SLOPE_W'(TERM_MAX));
      src2_r <= src1_r;
      ctl2_r <= ctl1_r;
    end
  end

  assign term_h   = th_r;
  assign term_v   = tv_r;
  assign term_pos = pos_r;
  assign src      = src2_r;
  assign ctl      = ctl2_r;

endmodule

FILE: design/blps_gain.sv
// ----------------------------------------------------------------------------
// blps_gain
// Stages 3-4: term product, then scaled light amount.
// ----------------------------------------------------------------------------
module blps_gain (
  input  logic                          clk,
  input  logic                          en3,
  input  logic                          en4,
  input  logic [blps_pkg::SCALE_W-1:0]  scaled_depth,
  input  logic [blps_pkg::TERM_W-1:0]   term_h,
  input  logic [blps_pkg::TERM_W-1:0]   term_v,
  input  logic                          term_pos,
  input  logic [blps_pkg::RGB_W-1:0]    src_in,
  input  blps_pkg::ctl_t                ctl_in,
  output logic [blps_pkg::AMT_W-1:0]    amount,
  output logic [blps_pkg::RGB_W-1:0]    src_out,
  output blps_pkg::ctl_t                ctl_out
);
  import blps_pkg::*;

  logic [TT_W-1:0]          tt_r;
  logic [RGB_W-1:0]         src3_r, src4_r;
  ctl_t                     ctl3_r, ctl4_r;
  logic [AMT_W-1:0]         amt_r;
  logic [TT_W+SCALE_W-1:0]  prod;

  always_ff @(posedge clk) begin
    if (en3) begin
      tt_r   <= term_pos ? TT_W'(term_h * term_v) : '0;
      src3_r <= src_in;
      ctl3_r <= ctl_in;
    end
  end

  assign prod = (TT_W+SCALE_W)'(tt_r) * (TT_W+SCALE_W)'(scaled_depth);

  always_ff @(posedge clk) begin
    if (en4) begin
      amt_r  <= AMT_W'(prod >> SHIFT_AMT);
      src4_r <= src3_r;
      ctl4_r <= ctl3_r;
    end
  end

  assign amount  = amt_r;
  assign src_out = src4_r;
  assign ctl_out = ctl4_r;

endmodule

FILE: design/blps_blend.sv
// ----------------------------------------------------------------------------
// blps_blend
// Stage 5: lift and cap channels, blend with source or pick marker/black, output register.
// ----------------------------------------------------------------------------
module blps_blend (
  input  logic                          clk,
  input  logic                          en5,
  input  logic [1:0]                    blend_mode,
  input  logic [blps_pkg::AMT_W-1:0]    amount,
  input  logic [blps_pkg::RGB_W-1:0]    src,
  input  blps_pkg::ctl_t                ctl,
  output logic [blps_pkg::RGB_W-1:0]    color
);
  import blps_pkg::*;

  logic [RGB_W-1:0] shaded, added, avg, blended, color_r;
  logic [AMT_W:0]   lift [3];
  logic [CH_W:0]    sum  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lift[k] = (AMT_W+1)'(src[8*k +: CH_W]) + (AMT_W+1)'(amount);
      shaded[8*k +: CH_W] = (lift[k] > (AMT_W+1)'(CH_CAP)) ? CH_CAP
                                                            : lift[k][CH_W-1:0];
      sum[k] = (CH_W+1)'(src[8*k +: CH_W]) + (CH_W+1)'(shaded[8*k +: CH_W]);
      added[8*k +: CH_W] = sum[k][CH_W] ? {CH_W{1'b1}} : sum[k][CH_W-1:0];
      avg[8*k +: CH_W] = CH_W'(src[8*k+1 +: CH_W-1]) +
                         CH_W'(shaded[8*k+1 +: CH_W-1]);
    end
    case (blend_mode)
      BLEND_ADD:  blended = added;
      BLEND_MEAN: blended = avg;
      default:    blended = shaded;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      color_r <= ctl.wr ? blended : (ctl.mark ? WHITE : '0);
    end
  end

  assign color = color_r;

endmodule
